[sv/mi3_pkg.sv]
// mi3_pkg: shared constants, widths and types for the 3x3 matrix inverse
// no dependencies; used by every other file of the block
`default_nettype none

package mi3_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_ELEMS     = 9;
    localparam int NUM_DET_TERMS = 3;
    localparam int FRONT_STAGES  = 6;

    // cofactor k (row-major inverse element) = e[x]*e[y] - e[u]*e[v]
    localparam int CF_X [NUM_ELEMS] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_Y [NUM_ELEMS] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_U [NUM_ELEMS] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
    localparam int CF_V [NUM_ELEMS] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};

    // det = e0*c0 + e1*c3 + e2*c6
    localparam int DET_COF [NUM_DET_TERMS] = '{0, 3, 6};

    function automatic int cof_bits(input int w);
        return 2 * w + 1;
    endfunction

    function automatic int det_bits(input int w);
        return 3 * w + 3;
    endfunction

    function automatic int num_bits(input int w, input int f);
        return 2 * w + 1 + 2 * f;
    endfunction

    typedef struct packed {
        logic valid;
        logic singular;
    } mi3_ctrl_t;

endpackage

`default_nettype wire

[sv/mi3_mat_if.sv]
// mi3_mat_if: input channel carrying one 3x3 matrix per item
// depends on mi3_pkg for the default word width
`default_nettype none

interface mi3_mat_if #(
    parameter int W = mi3_pkg::WORD_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_r1c1;
    logic signed [W-1:0] a_r1c2;
    logic signed [W-1:0] a_r1c3;
    logic signed [W-1:0] a_r2c1;
    logic signed [W-1:0] a_r2c2;
    logic signed [W-1:0] a_r2c3;
    logic signed [W-1:0] a_r3c1;
    logic signed [W-1:0] a_r3c2;
    logic signed [W-1:0] a_r3c3;

    modport source (
        output valid, a_r1c1, a_r1c2, a_r1c3, a_r2c1, a_r2c2, a_r2c3,
               a_r3c1, a_r3c2, a_r3c3,
        input  ready
    );
    modport sink (
        input  valid, a_r1c1, a_r1c2, a_r1c3, a_r2c1, a_r2c2, a_r2c3,
               a_r3c1, a_r3c2, a_r3c3,
        output ready
    );
endinterface

`default_nettype wire

[sv/mi3_inv_if.sv]
// mi3_inv_if: output channel carrying one inverse matrix and flags per item
// depends on mi3_pkg for the default word width
`default_nettype none

interface mi3_inv_if #(
    parameter int W = mi3_pkg::WORD_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] inv_r1c1;
    logic signed [W-1:0] inv_r1c2;
    logic signed [W-1:0] inv_r1c3;
    logic signed [W-1:0] inv_r2c1;
    logic signed [W-1:0] inv_r2c2;
    logic signed [W-1:0] inv_r2c3;
    logic signed [W-1:0] inv_r3c1;
    logic signed [W-1:0] inv_r3c2;
    logic signed [W-1:0] inv_r3c3;
    logic                singular;
    logic                overflow;

    modport source (
        output valid, inv_r1c1, inv_r1c2, inv_r1c3, inv_r2c1, inv_r2c2, inv_r2c3,
               inv_r3c1, inv_r3c2, inv_r3c3, singular, overflow,
        input  ready
    );
    modport sink (
        input  valid, inv_r1c1, inv_r1c2, inv_r1c3, inv_r2c1, inv_r2c2, inv_r2c3,
               inv_r3c1, inv_r3c2, inv_r3c3, singular, overflow,
        output ready
    );
endinterface

`default_nettype wire

[sv/mi3_front.sv]
// mi3_front: cofactors, determinant and magnitudes, six pipeline stages
// depends on mi3_pkg
`default_nettype none

module mi3_front #(
    parameter  int W  = mi3_pkg::WORD_BITS_DEF,
    parameter  int F  = mi3_pkg::FRAC_BITS_DEF,
    localparam int NW = mi3_pkg::num_bits(W, F),
    localparam int DW = mi3_pkg::det_bits(W)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic signed [W-1:0] elem [mi3_pkg::NUM_ELEMS],
    output mi3_pkg::mi3_ctrl_t       ctrl,
    output logic [NW-1:0]            num_mag [mi3_pkg::NUM_ELEMS],
    output logic                     num_neg [mi3_pkg::NUM_ELEMS],
    output logic [DW-1:0]            det_mag,
    output logic                     det_neg
);
    localparam int CW = mi3_pkg::cof_bits(W);
    localparam int PW = 2 * W;
    localparam int NE = mi3_pkg::NUM_ELEMS;
    localparam int NT = mi3_pkg::NUM_DET_TERMS;
    localparam int FS = mi3_pkg::FRONT_STAGES;

    logic [FS-1:0]         vld_reg;
    logic signed [PW-1:0]  pa_reg   [NE];
    logic signed [PW-1:0]  pb_reg   [NE];
    logic signed [W-1:0]   s1_e_reg [NT];
    logic signed [W-1:0]   s2_e_reg [NT];
    logic signed [CW-1:0]  s2_cof_reg [NE];
    logic signed [CW-1:0]  s3_cof_reg [NE];
    logic signed [CW-1:0]  s4_cof_reg [NE];
    logic signed [CW-1:0]  s5_cof_reg [NE];
    logic signed [PW:0]    lo_reg   [NT];
    logic signed [PW:0]    hi_reg   [NT];
    logic signed [DW-1:0]  term_reg [NT];
    logic signed [DW-1:0]  det_reg;
    logic                  zero_reg;
    logic [CW-1:0]         cof_abs  [NE];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FS-2:0], in_valid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < NE; k++)
        begin
            cof_abs[k] = s5_cof_reg[k][CW-1] ? CW'(-s5_cof_reg[k]) : CW'(s5_cof_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products
            for (int k = 0; k < NE; k++)
            begin
                pa_reg[k] <= elem[mi3_pkg::CF_X[k]] * elem[mi3_pkg::CF_Y[k]];
                pb_reg[k] <= elem[mi3_pkg::CF_U[k]] * elem[mi3_pkg::CF_V[k]];
            end
            for (int t = 0; t < NT; t++)
            begin
                s1_e_reg[t] <= elem[t];
                s2_e_reg[t] <= s1_e_reg[t];
            end
            // cofactors
            for (int k = 0; k < NE; k++)
            begin
                s2_cof_reg[k] <= CW'(pa_reg[k]) - CW'(pb_reg[k]);
                s3_cof_reg[k] <= s2_cof_reg[k];
                s4_cof_reg[k] <= s3_cof_reg[k];
                s5_cof_reg[k] <= s4_cof_reg[k];
            end
            // determinant partial products, split cofactor in low and high halves
            for (int t = 0; t < NT; t++)
            begin
                lo_reg[t] <= s2_e_reg[t] *
                             $signed({1'b0, s2_cof_reg[mi3_pkg::DET_COF[t]][W-1:0]});
                hi_reg[t] <= s2_e_reg[t] *
                             $signed(s2_cof_reg[mi3_pkg::DET_COF[t]][CW-1:W]);
                term_reg[t] <= (DW'(hi_reg[t]) <<< W) + DW'(lo_reg[t]);
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            // magnitudes for the division lanes
            for (int k = 0; k < NE; k++)
            begin
                num_mag[k] <= {cof_abs[k], {(2 * F){1'b0}}};
                num_neg[k] <= s5_cof_reg[k][CW-1];
            end
            det_mag  <= det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
            det_neg  <= det_reg[DW-1];
            zero_reg <= (det_reg == '0);
        end
    end

    assign ctrl.valid    = vld_reg[FS-1];
    assign ctrl.singular = zero_reg;

endmodule

`default_nettype wire

[sv/mi3_lane.sv]
// mi3_lane: one division lane, rounded and saturated quotient of num*2^2F/det
// depends on mi3_pkg
`default_nettype none

module mi3_lane #(
    parameter  int W  = mi3_pkg::WORD_BITS_DEF,
    parameter  int F  = mi3_pkg::FRAC_BITS_DEF,
    localparam int NW = mi3_pkg::num_bits(W, F),
    localparam int DW = mi3_pkg::det_bits(W)
) (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [NW-1:0]       num_mag,
    input  wire logic                num_neg,
    input  wire logic [DW-1:0]       det_mag,
    input  wire logic                det_neg,
    output logic signed [W-1:0]      res,
    output logic                     ovf
);
    localparam int HW = NW - W;
    localparam int XW = (HW > DW) ? HW : DW;

    // stage 0 holds the screened partial remainder, stages 1..W one quotient bit each
    logic [DW-1:0] rem_reg  [W+1];
    logic [W-1:0]  low_reg  [W+1];
    logic [W-1:0]  quo_reg  [W+1];
    logic [DW-1:0] dm_reg   [W+1];
    logic          big_reg  [W+1];
    logic          neg_reg  [W+1];

    logic          big;
    logic          up;
    logic [W:0]    qv;
    logic [W:0]    lim;
    logic          negq;
    logic          sat;
    logic [W:0]    qs;

    // quotient at least 2^W when the high part of the numerator reaches det
    assign big = XW'(num_mag[NW-1:W]) >= XW'(det_mag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= big ? '0 : DW'(num_mag[NW-1:W]);
            low_reg[0] <= num_mag[W-1:0];
            quo_reg[0] <= '0;
            dm_reg[0]  <= det_mag;
            big_reg[0] <= big;
            neg_reg[0] <= num_neg ^ det_neg;
        end
    end

    for (genvar j = 0; j < W; j++)
    begin : g_step
        logic [DW:0] trial;
        logic        fit;

        assign trial = {rem_reg[j], low_reg[j][W-1]};
        assign fit   = trial >= {1'b0, dm_reg[j]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= fit ? DW'(trial - {1'b0, dm_reg[j]}) : DW'(trial);
                low_reg[j+1] <= {low_reg[j][W-2:0], 1'b0};
                quo_reg[j+1] <= {quo_reg[j][W-2:0], fit};
                dm_reg[j+1]  <= dm_reg[j];
                big_reg[j+1] <= big_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    // round half away from zero, then saturate
    always_comb
    begin
        up   = {rem_reg[W], 1'b0} >= {1'b0, dm_reg[W]};
        qv   = {1'b0, quo_reg[W]} + (W+1)'(up);
        negq = neg_reg[W] && (big_reg[W] || (qv != '0));
        lim  = (W+1)'({1'b0, {(W-1){1'b1}}}) + (W+1)'(negq);
        sat  = big_reg[W] || (qv > lim);
        qs   = sat ? lim : qv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res <= negq ? $signed(W'(-qs)) : $signed(W'(qs));
            ovf <= sat;
        end
    end

endmodule

`default_nettype wire

[sv/mi3_merge.sv]
// mi3_merge: combines the nine lane results into the output register
// depends on mi3_pkg
`default_nettype none

module mi3_merge #(
    parameter int W = mi3_pkg::WORD_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire mi3_pkg::mi3_ctrl_t  ctrl,
    input  wire logic signed [W-1:0] res [mi3_pkg::NUM_ELEMS],
    input  wire logic                ovf [mi3_pkg::NUM_ELEMS],
    output logic                     out_valid,
    output logic signed [W-1:0]      elem [mi3_pkg::NUM_ELEMS],
    output logic                     singular,
    output logic                     overflow
);
    localparam int NE = mi3_pkg::NUM_ELEMS;

    logic any_ovf;

    always_comb
    begin
        any_ovf = 1'b0;
        for (int k = 0; k < NE; k++)
        begin
            any_ovf = any_ovf | ovf[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NE; k++)
            begin
                elem[k] <= ctrl.singular ? '0 : res[k];
            end
            singular <= ctrl.singular;
            overflow <= ctrl.singular ? 1'b0 : any_ovf;
        end
    end

endmodule

`default_nettype wire

[sv/matrix_inverse_3x3_unit.sv]
// matrix_inverse_3x3_unit: pipelined 3x3 inverse by the adjugate, signed fixed point
// depends on mi3_pkg, mi3_mat_if, mi3_inv_if, mi3_front, mi3_lane, mi3_merge
//
//   channel | dir | payload                                   | per item
//   --------+-----+-------------------------------------------+--------------
//   mat     | in  | a_r1c1 .. a_r3c3, signed Q16.16           | one matrix
//   inv     | out | inv_r1c1 .. inv_r3c3, singular, overflow  | one inverse
//
// one item enters per cycle while the pipeline advances; an item passes six front stages,
// one screening stage, one stage per quotient bit and a rounding stage in each
// of the nine division lanes, then the output register
// the whole pipeline advances whenever the output register is empty or taken,
// so a waiting result stalls every stage and input alike
// reset clears only the valid bits and the flags that travel beside the lanes; no clearing pass
`default_nettype none

module matrix_inverse_3x3_unit #(
    parameter int WORD_BITS = mi3_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    mi3_mat_if.sink  mat,
    mi3_inv_if.source inv
);
    localparam int W  = WORD_BITS;
    localparam int NE = mi3_pkg::NUM_ELEMS;
    localparam int NW = mi3_pkg::num_bits(WORD_BITS, FRAC_BITS);
    localparam int DW = mi3_pkg::det_bits(WORD_BITS);
    localparam int LL = WORD_BITS + 2;   // division lane latency

    logic                 en;
    logic signed [W-1:0]  elem_in  [NE];
    mi3_pkg::mi3_ctrl_t   front_ctrl;
    logic [NW-1:0]        num_mag  [NE];
    logic                 num_neg  [NE];
    logic [DW-1:0]        det_mag;
    logic                 det_neg;
    logic signed [W-1:0]  lane_res [NE];
    logic                 lane_ovf [NE];
    mi3_pkg::mi3_ctrl_t   ctrl_reg [LL];
    logic signed [W-1:0]  out_elem [NE];
    logic                 out_valid;
    logic                 out_singular;
    logic                 out_overflow;

    // global advance: output register free or being taken
    assign en        = !out_valid || inv.ready;
    assign mat.ready = en;

    assign elem_in[0] = mat.a_r1c1;
    assign elem_in[1] = mat.a_r1c2;
    assign elem_in[2] = mat.a_r1c3;
    assign elem_in[3] = mat.a_r2c1;
    assign elem_in[4] = mat.a_r2c2;
    assign elem_in[5] = mat.a_r2c3;
    assign elem_in[6] = mat.a_r3c1;
    assign elem_in[7] = mat.a_r3c2;
    assign elem_in[8] = mat.a_r3c3;

    // cofactors and determinant, shared by all lanes
    mi3_front #(
        .W (WORD_BITS),
        .F (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (mat.valid),
        .elem     (elem_in),
        .ctrl     (front_ctrl),
        .num_mag  (num_mag),
        .num_neg  (num_neg),
        .det_mag  (det_mag),
        .det_neg  (det_neg)
    );

    // nine lanes, one per inverse element
    for (genvar k = 0; k < NE; k++)
    begin : g_lane
        mi3_lane #(
            .W (WORD_BITS),
            .F (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .num_mag (num_mag[k]),
            .num_neg (num_neg[k]),
            .det_mag (det_mag),
            .det_neg (det_neg),
            .res     (lane_res[k]),
            .ovf     (lane_ovf[k])
        );
    end

    // item flags travel beside the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LL; s++)
            begin
                ctrl_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            ctrl_reg[0] <= front_ctrl;
            for (int s = 1; s < LL; s++)
            begin
                ctrl_reg[s] <= ctrl_reg[s-1];
            end
        end
    end

    mi3_merge #(
        .W (WORD_BITS)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctrl      (ctrl_reg[LL-1]),
        .res       (lane_res),
        .ovf       (lane_ovf),
        .out_valid (out_valid),
        .elem      (out_elem),
        .singular  (out_singular),
        .overflow  (out_overflow)
    );

    assign inv.valid    = out_valid;
    assign inv.inv_r1c1 = out_elem[0];
    assign inv.inv_r1c2 = out_elem[1];
    assign inv.inv_r1c3 = out_elem[2];
    assign inv.inv_r2c1 = out_elem[3];
    assign inv.inv_r2c2 = out_elem[4];
    assign inv.inv_r2c3 = out_elem[5];
    assign inv.inv_r3c1 = out_elem[6];
    assign inv.inv_r3c2 = out_elem[7];
    assign inv.inv_r3c3 = out_elem[8];
    assign inv.singular = out_singular;
    assign inv.overflow = out_overflow;

endmodule

`default_nettype wire
